[hw/rtl/cilvt_pkg.sv]
// Shared types and codes of the CAN identifier last-value table.
package cilvt_pkg;

    localparam int unsigned ID_W   = 29;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned STAT_W = 2;

    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 112;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_DUMP  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [2*DATA_W-1:0] payload;
    } t_entry;

    typedef enum logic [2:0] {
        RES_UPDATE,
        RES_INSERT,
        RES_DROP,
        RES_EMPTY,
        RES_ENTRY
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_RESULT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic search_en;
        logic dump_rd;
        logic load_out;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic hit;
        logic scan_done;
        logic full;
        logic empty;
        logic dump_last;
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/cilvt_ctrl.sv]
// Controller state machine of the CAN identifier last-value table.
module cilvt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cilvt_pkg::t_stat i_stat,
    output cilvt_pkg::t_cmd  o_cmd
);

    cilvt_pkg::t_state r_state, n_state;
    cilvt_pkg::t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cilvt_pkg::S_IDLE;
            r_res   <= cilvt_pkg::RES_DROP;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            cilvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cilvt_pkg::S_DECODE;
                end
            end
            cilvt_pkg::S_DECODE: begin
                if (i_stat.op == cilvt_pkg::OP_DUMP) begin
                    if (i_stat.empty) begin
                        n_state = cilvt_pkg::S_RESULT;
                        n_res   = cilvt_pkg::RES_EMPTY;
                    end else begin
                        n_state = cilvt_pkg::S_DUMP_RD;
                    end
                end else begin
                    n_state = cilvt_pkg::S_SEARCH;
                end
            end
            cilvt_pkg::S_SEARCH: begin
                if (i_stat.hit) begin
                    n_state = cilvt_pkg::S_RESULT;
                    n_res   = cilvt_pkg::RES_UPDATE;
                end else if (i_stat.scan_done) begin
                    n_state = cilvt_pkg::S_RESULT;
                    n_res   = i_stat.full ? cilvt_pkg::RES_DROP : cilvt_pkg::RES_INSERT;
                end
            end
            cilvt_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = cilvt_pkg::S_IDLE;
                end
            end
            cilvt_pkg::S_DUMP_RD: begin
                n_state = cilvt_pkg::S_DUMP_OUT;
            end
            cilvt_pkg::S_DUMP_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.dump_last ? cilvt_pkg::S_IDLE : cilvt_pkg::S_DUMP_RD;
                end
            end
            default: begin
                n_state = cilvt_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.search_en = 1'b0;
        o_cmd.dump_rd   = 1'b0;
        o_cmd.load_out  = 1'b0;
        o_cmd.res       = r_res;
        unique case (r_state)
            cilvt_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            cilvt_pkg::S_SEARCH: begin
                o_cmd.search_en = 1'b1;
            end
            cilvt_pkg::S_RESULT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            cilvt_pkg::S_DUMP_RD: begin
                o_cmd.dump_rd = 1'b1;
            end
            cilvt_pkg::S_DUMP_OUT: begin
                o_cmd.load_out = i_stat.out_free;
                o_cmd.res      = cilvt_pkg::RES_ENTRY;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/cilvt_dp.sv]
// Datapath of the CAN identifier last-value table: entry memory, scan counter, result register.
module cilvt_dp #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cilvt_pkg::t_cmd                   i_cmd,
    output cilvt_pkg::t_stat                  o_stat,
    input  logic                              i_op,
    input  logic [cilvt_pkg::ID_W-1:0]        i_frame_id,
    input  logic [cilvt_pkg::LEN_W-1:0]       i_frame_len,
    input  logic [cilvt_pkg::DATA_W-1:0]      i_data_high,
    input  logic [cilvt_pkg::DATA_W-1:0]      i_data_low,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [cilvt_pkg::KIND_W-1:0]      o_kind,
    output logic [cilvt_pkg::STAT_W-1:0]      o_status,
    output logic [cilvt_pkg::IDX_W-1:0]       o_entry_index,
    output logic [cilvt_pkg::ID_W-1:0]        o_out_id,
    output logic [cilvt_pkg::LEN_W-1:0]       o_out_len,
    output logic [cilvt_pkg::DATA_W-1:0]      o_out_data_high,
    output logic [cilvt_pkg::DATA_W-1:0]      o_out_data_low,
    output logic                              o_last
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    cilvt_pkg::t_entry r_mem [TABLE_ENTRIES];

    logic                              r_in_op;
    logic [cilvt_pkg::ID_W-1:0]        r_in_id;
    logic [cilvt_pkg::LEN_W-1:0]       r_in_len;
    logic [2*cilvt_pkg::DATA_W-1:0]    r_in_pay;

    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_addr;
    logic [AW-1:0]     r_pidx;
    logic              r_pend;
    cilvt_pkg::t_entry r_rd_data;

    logic              hit;
    logic              more;
    logic              rd_fire;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    cilvt_pkg::t_entry wr_data;
    logic [CW-1:0]     pidx_next;

    logic [cilvt_pkg::KIND_W-1:0]  n_kind;
    logic [cilvt_pkg::STAT_W-1:0]  n_status;
    logic [cilvt_pkg::IDX_W-1:0]   n_entry_index;
    logic [cilvt_pkg::ID_W-1:0]    n_out_id;
    logic [cilvt_pkg::LEN_W-1:0]   n_out_len;
    logic [cilvt_pkg::DATA_W-1:0]  n_out_data_high;
    logic [cilvt_pkg::DATA_W-1:0]  n_out_data_low;
    logic                          n_last;

    assign more      = (r_addr < r_fill);
    assign hit       = r_pend && (r_rd_data.id == r_in_id);
    assign rd_fire   = (i_cmd.search_en && !hit && more) || i_cmd.dump_rd;
    assign pidx_next = CW'(r_pidx) + CW'(1);

    assign o_stat.op        = r_in_op;
    assign o_stat.hit       = hit;
    assign o_stat.scan_done = !r_pend && !more;
    assign o_stat.full      = (r_fill == CW'(TABLE_ENTRIES));
    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.dump_last = (pidx_next == r_fill);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op  <= i_op;
            r_in_id  <= i_frame_id;
            r_in_len <= i_frame_len;
            r_in_pay <= {i_data_high, i_data_low};
        end
    end

    // Scan address and compare-pending flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.capture) begin
            r_addr <= '0;
            r_pend <= 1'b0;
        end else begin
            if (rd_fire) begin
                r_addr <= r_addr + CW'(1);
            end
            if (i_cmd.search_en && !hit) begin
                r_pend <= more;
            end
        end
    end

    always_comb begin
        wr_en   = i_cmd.load_out && (i_cmd.res == cilvt_pkg::RES_UPDATE
                                     || i_cmd.res == cilvt_pkg::RES_INSERT);
        wr_addr = r_pidx;
        wr_data = '{id: r_rd_data.id, len: r_rd_data.len, payload: r_in_pay};
        if (i_cmd.res == cilvt_pkg::RES_INSERT) begin
            wr_addr = r_fill[AW-1:0];
            wr_data = '{id: r_in_id, len: r_in_len, payload: r_in_pay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_fire) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
            r_pidx    <= r_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load_out && i_cmd.res == cilvt_pkg::RES_INSERT) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_kind          = cilvt_pkg::KIND_STATUS;
        n_status        = cilvt_pkg::STAT_UPDATED;
        n_entry_index   = '0;
        n_out_id        = '0;
        n_out_len       = '0;
        n_out_data_high = '0;
        n_out_data_low  = '0;
        n_last          = 1'b1;
        unique case (i_cmd.res)
            cilvt_pkg::RES_UPDATE: begin
                n_entry_index   = cilvt_pkg::IDX_W'(r_pidx);
                n_out_id        = r_rd_data.id;
                n_out_len       = r_rd_data.len;
                n_out_data_high = r_in_pay[2*cilvt_pkg::DATA_W-1:cilvt_pkg::DATA_W];
                n_out_data_low  = r_in_pay[cilvt_pkg::DATA_W-1:0];
            end
            cilvt_pkg::RES_INSERT: begin
                n_status        = cilvt_pkg::STAT_INSERTED;
                n_entry_index   = cilvt_pkg::IDX_W'(r_fill);
                n_out_id        = r_in_id;
                n_out_len       = r_in_len;
                n_out_data_high = r_in_pay[2*cilvt_pkg::DATA_W-1:cilvt_pkg::DATA_W];
                n_out_data_low  = r_in_pay[cilvt_pkg::DATA_W-1:0];
            end
            cilvt_pkg::RES_DROP: begin
                n_status = cilvt_pkg::STAT_DROPPED;
            end
            cilvt_pkg::RES_EMPTY: begin
                n_kind = cilvt_pkg::KIND_EMPTY;
            end
            cilvt_pkg::RES_ENTRY: begin
                n_kind          = cilvt_pkg::KIND_ENTRY;
                n_entry_index   = cilvt_pkg::IDX_W'(r_pidx);
                n_out_id        = r_rd_data.id;
                n_out_len       = r_rd_data.len;
                n_out_data_high = r_rd_data.payload[2*cilvt_pkg::DATA_W-1:cilvt_pkg::DATA_W];
                n_out_data_low  = r_rd_data.payload[cilvt_pkg::DATA_W-1:0];
                n_last          = o_stat.dump_last;
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_kind          <= n_kind;
            o_status        <= n_status;
            o_entry_index   <= n_entry_index;
            o_out_id        <= n_out_id;
            o_out_len       <= n_out_len;
            o_out_data_high <= n_out_data_high;
            o_out_data_low  <= n_out_data_low;
            o_last          <= n_last;
        end
    end

endmodule

[hw/rtl/can_id_last_value_table_top.sv]
// Top level of the CAN identifier last-value table: stream ports, controller and datapath.
// Store: the identifier is compared with the filled entries in slot order; a match refreshes
// that entry's payload, a miss appends the frame or drops it when the table is full, and
// one status word follows. Dump: every filled entry in slot order, or one empty notice.
// One word at a time; a new word is taken from the cycle after the last result load on.
// Reset (synchronous, active low) clears the state machine and empties the table at once.
module can_id_last_value_table_top #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata from bit 0 up: frame_id[28:0], frame_len[32:29], data_high[64:33],
    // data_low[96:65], zero padding [103:97].
    input  logic [cilvt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: op (0 = store frame, 1 = dump table).
    input  logic                                  s_axis_tuser,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata from bit 0 up: status[1:0], entry_index[7:2], out_id[36:8], out_len[40:37],
    // out_data_high[72:41], out_data_low[104:73], zero padding [111:105].
    output logic [cilvt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser: kind (0 = store status, 1 = table entry, 2 = empty notice).
    output logic [cilvt_pkg::KIND_W-1:0]          m_axis_tuser,
    // tlast marks the final word caused by one input word.
    output logic                                  m_axis_tlast
);

    cilvt_pkg::t_cmd  cmd;
    cilvt_pkg::t_stat stat;

    logic [cilvt_pkg::STAT_W-1:0] out_status;
    logic [cilvt_pkg::IDX_W-1:0]  out_index;
    logic [cilvt_pkg::ID_W-1:0]   out_id;
    logic [cilvt_pkg::LEN_W-1:0]  out_len;
    logic [cilvt_pkg::DATA_W-1:0] out_dh;
    logic [cilvt_pkg::DATA_W-1:0] out_dl;

    // The controller sequences decode, the identifier scan, the result load and the dump.
    cilvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the entry memory, the fill count and the output register.
    cilvt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (s_axis_tuser),
        .i_frame_id      (s_axis_tdata[28:0]),
        .i_frame_len     (s_axis_tdata[32:29]),
        .i_data_high     (s_axis_tdata[64:33]),
        .i_data_low      (s_axis_tdata[96:65]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_kind          (m_axis_tuser),
        .o_status        (out_status),
        .o_entry_index   (out_index),
        .o_out_id        (out_id),
        .o_out_len       (out_len),
        .o_out_data_high (out_dh),
        .o_out_data_low  (out_dl),
        .o_last          (m_axis_tlast)
    );

    // Pack the result fields, lowest field first, and pad to whole bytes.
    assign m_axis_tdata = {7'd0, out_dl, out_dh, out_len, out_id, out_index, out_status};

endmodule

[tb/sv/tb_can_id_last_value_table_top.sv]
// Self-checking stream testbench for the CAN identifier last-value table.
module tb_can_id_last_value_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 64;

    // One command word for the table, together with the handshake behavior
    // that applies while it is offered.
    typedef struct {
        logic                         op;
        logic [cilvt_pkg::ID_W-1:0]   id;
        logic [cilvt_pkg::LEN_W-1:0]  len;
        logic [cilvt_pkg::DATA_W-1:0] data_high;
        logic [cilvt_pkg::DATA_W-1:0] data_low;
        int                           idle_pct;
        int                           stall_pct;
        bit                           drain;
    } t_table_cmd;

    // One word that the table sends back, split into its fields.
    typedef struct {
        logic [cilvt_pkg::KIND_W-1:0] kind;
        logic [cilvt_pkg::STAT_W-1:0] status;
        logic [cilvt_pkg::IDX_W-1:0]  slot;
        logic [cilvt_pkg::ID_W-1:0]   id;
        logic [cilvt_pkg::LEN_W-1:0]  len;
        logic [cilvt_pkg::DATA_W-1:0] data_high;
        logic [cilvt_pkg::DATA_W-1:0] data_low;
        logic                         last;
    } t_table_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [cilvt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tuser = cilvt_pkg::OP_STORE;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [cilvt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [cilvt_pkg::KIND_W-1:0]      m_axis_tuser;
    logic                              m_axis_tlast;

    // Output fields as laid out in m_axis_tdata.
    wire [cilvt_pkg::STAT_W-1:0] got_status    = m_axis_tdata[1:0];
    wire [cilvt_pkg::IDX_W-1:0]  got_slot      = m_axis_tdata[7:2];
    wire [cilvt_pkg::ID_W-1:0]   got_id        = m_axis_tdata[36:8];
    wire [cilvt_pkg::LEN_W-1:0]  got_len       = m_axis_tdata[40:37];
    wire [cilvt_pkg::DATA_W-1:0] got_data_high = m_axis_tdata[72:41];
    wire [cilvt_pkg::DATA_W-1:0] got_data_low  = m_axis_tdata[104:73];

    can_id_last_value_table_top #(
        .TABLE_ENTRIES(SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Commands waiting to be offered, and the words the table owes us.
    t_table_cmd    frames_to_send[$];
    t_table_report table_reports[$];
    t_table_cmd    in_flight;
    t_table_report want;
    logic [cilvt_pkg::ID_W-1:0] known_ids[$];

    // Shadow copy of the table contents, filled in slot order.
    cilvt_pkg::t_entry mirror[SLOTS];
    int                mirror_fill = 0;

    int frames_total    = 0;
    int frames_accepted = 0;
    int fault_count     = 0;
    int stall_pct       = 0;
    bit word_taken      = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Works out the words that one accepted command causes and updates the
    // shadow table. A store either refreshes the payload of the first entry
    // with the same identifier (the original length is kept), appends a new
    // entry, or is dropped when the table is full. A dump lists every filled
    // entry in slot order, or sends a single empty notice.
    task automatic table_apply(input t_table_cmd c);
        t_table_report r;
        int hit;
        hit = -1;
        r = '{cilvt_pkg::KIND_STATUS, cilvt_pkg::STAT_UPDATED, '0, '0, '0, '0, '0, 1'b1};
        if (c.op == cilvt_pkg::OP_STORE) begin
            for (int i = 0; i < mirror_fill; i++) begin
                if (hit < 0 && mirror[i].id == c.id) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                mirror[hit].payload = {c.data_high, c.data_low};
                r.status    = cilvt_pkg::STAT_UPDATED;
                r.slot      = cilvt_pkg::IDX_W'(hit);
                r.id        = mirror[hit].id;
                r.len       = mirror[hit].len;
                r.data_high = c.data_high;
                r.data_low  = c.data_low;
            end else if (mirror_fill >= SLOTS) begin
                r.status = cilvt_pkg::STAT_DROPPED;
            end else begin
                mirror[mirror_fill] = '{c.id, c.len, {c.data_high, c.data_low}};
                r.status    = cilvt_pkg::STAT_INSERTED;
                r.slot      = cilvt_pkg::IDX_W'(mirror_fill);
                r.id        = c.id;
                r.len       = c.len;
                r.data_high = c.data_high;
                r.data_low  = c.data_low;
                mirror_fill++;
            end
            table_reports.insert(table_reports.size(), r);
        end else if (mirror_fill == 0) begin
            r.kind = cilvt_pkg::KIND_EMPTY;
            table_reports.insert(table_reports.size(), r);
        end else begin
            for (int i = 0; i < mirror_fill; i++) begin
                r.kind      = cilvt_pkg::KIND_ENTRY;
                r.status    = cilvt_pkg::STAT_UPDATED;
                r.slot      = cilvt_pkg::IDX_W'(i);
                r.id        = mirror[i].id;
                r.len       = mirror[i].len;
                r.data_high = mirror[i].payload[2*cilvt_pkg::DATA_W-1:cilvt_pkg::DATA_W];
                r.data_low  = mirror[i].payload[cilvt_pkg::DATA_W-1:0];
                r.last      = (i == mirror_fill - 1);
                table_reports.insert(table_reports.size(), r);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, exp_val, act_val);
            fault_count++;
        end
    endtask

    task automatic push_frame(input logic op, input logic [cilvt_pkg::ID_W-1:0] id,
                              input logic [cilvt_pkg::LEN_W-1:0] len,
                              input logic [cilvt_pkg::DATA_W-1:0] dh,
                              input logic [cilvt_pkg::DATA_W-1:0] dl, input int idle,
                              input int stall, input bit drain);
        t_table_cmd c;
        c = '{op, id, len, dh, dl, idle, stall, drain};
        frames_to_send.insert(frames_to_send.size(), c);
        frames_total++;
    endtask

    // Random commands for one idling phase. About half of the stores reuse an
    // identifier already sent, so updates stay common; the rest bring new
    // identifiers (standard or extended) that fill the table and, once it is
    // full, get dropped. Lengths beyond eight show up now and then. The first
    // word of each phase waits until the table has answered everything.
    task automatic queue_random_frames(input int count, input int idle, input int stall);
        logic                        op;
        logic [cilvt_pkg::ID_W-1:0]  id;
        logic [cilvt_pkg::LEN_W-1:0] len;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < 9) ? cilvt_pkg::OP_DUMP : cilvt_pkg::OP_STORE;
            if (known_ids.size() != 0 && $urandom_range(0, 1) == 1) begin
                id = known_ids[$urandom_range(0, known_ids.size() - 1)];
            end else begin
                id = $urandom_range(0, 1) ? cilvt_pkg::ID_W'($urandom_range(0, 2047))
                                          : cilvt_pkg::ID_W'($urandom);
                known_ids.insert(known_ids.size(), id);
            end
            len = ($urandom_range(0, 9) == 0) ? cilvt_pkg::LEN_W'($urandom_range(9, 15))
                                              : cilvt_pkg::LEN_W'($urandom_range(0, 8));
            push_frame(op, id, len, $urandom, $urandom, idle, stall, n == 0);
        end
    endtask

    // Driver: a new word goes out on the falling edge once the previous one
    // was taken. The output side's ready is redrawn on every falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (!s_axis_tvalid || word_taken) begin
                if (frames_to_send.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (frames_to_send[0].drain && table_reports.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < frames_to_send[0].idle_pct) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    in_flight = frames_to_send.pop_front();
                    stall_pct = in_flight.stall_pct;
                    s_axis_tdata <= {7'b0, in_flight.data_low, in_flight.data_high,
                                     in_flight.len, in_flight.id};
                    s_axis_tuser <= in_flight.op;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks every word taken from the output against the oldest
    // expected one, then predicts what a newly accepted command will cause.
    // The output check comes first because no command answers on the edge
    // that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (table_reports.size() == 0) begin
                    $display("%0t ns: unexpected word, got kind 0x%0h tdata 0x%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    fault_count++;
                end else begin
                    want = table_reports.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("status", 32'(want.status), 32'(got_status));
                    check_field("entry_index", 32'(want.slot), 32'(got_slot));
                    check_field("out_id", 32'(want.id), 32'(got_id));
                    check_field("out_len", 32'(want.len), 32'(got_len));
                    check_field("out_data_high", want.data_high, got_data_high);
                    check_field("out_data_low", want.data_low, got_data_low);
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                table_apply(in_flight);
                frames_accepted++;
            end
            word_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    initial begin
        // Directed part, no idling: empty dump, field extremes, an update
        // that must keep the first length, a length above eight, and dumps
        // of a partly filled table.
        push_frame(cilvt_pkg::OP_DUMP, '0, '0, '0, '0, 0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, '0, 4'd0, 32'h0, 32'h0, 0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h1FFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, '0, 4'd8, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h7FF, 4'd8, 32'h0123_4567, 32'h89AB_CDEF,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h1FFF_FFFF, 4'd0, 32'h0, 32'h0, 0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h0234_5678, 4'd9, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_DUMP, 29'h1FFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h1555_5555, 4'd5, 32'h5555_5555, 32'hAAAA_AAAA,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h0AAA_AAAA, 4'd10, 32'hAAAA_AAAA, 32'h5555_5555,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_STORE, 29'h7FF, 4'd3, 32'h8000_0001, 32'h0000_0001,
                   0, 0, 1'b0);
        push_frame(cilvt_pkg::OP_DUMP, '0, '0, '0, '0, 0, 0, 1'b0);
        known_ids = '{29'h0, 29'h1FFF_FFFF, 29'h7FF, 29'h0234_5678, 29'h1555_5555,
                      29'h0AAA_AAAA};

        // Random part in four idling phases.
        queue_random_frames(108, 0, 0);
        queue_random_frames(108, 49, 0);
        queue_random_frames(108, 0, 49);
        queue_random_frames(108, 22, 22);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (frames_accepted < frames_total || table_reports.size() != 0) begin
            @(negedge i_clk);
        end
        // A little extra time so that any stray word still gets flagged.
        repeat (100) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, far beyond a full run with every dump at its largest.
    initial begin
        #(8_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

[can_id_last_value_table_top.f]
hw/rtl/cilvt_pkg.sv
hw/rtl/cilvt_ctrl.sv
hw/rtl/cilvt_dp.sv
hw/rtl/can_id_last_value_table_top.sv
tb/sv/tb_can_id_last_value_table_top.sv
